// ===== rtl/core/scm_pkg.sv =====
`timescale 1ns / 1ps
package scm_pkg;

  localparam int MAX_CHUNKS  = 64;
  localparam int OFFSET_BITS = 48;
  localparam int END_BITS    = OFFSET_BITS + 1;   // offset + count - 1
  localparam int CNT_BITS    = 32;
  localparam int CHUNK_BITS  = 25;
  localparam int STRIPE_BITS = 31;
  localparam int SCNT_BITS   = 11;
  localparam int SRV_BITS    = 10;
  localparam int MAX_SERVERS = 1024;
  localparam int CFG_BITS    = 31;
  localparam int IDX_BITS    = $clog2(MAX_CHUNKS) > 0 ? $clog2(MAX_CHUNKS) : 1;

  // serial divider
  localparam int DIV_STEPS = END_BITS;
  localparam int DCNT_BITS = $clog2(DIV_STEPS);

  // request queue
  localparam int QDEPTH = 2;
  localparam int QPTR_BITS = 1;

  // register indexes
  localparam logic [1:0] REG_CHUNK_BYTES  = 2'd0;
  localparam logic [1:0] REG_STRIPE_SIZE  = 2'd1;
  localparam logic [1:0] REG_SERVER_COUNT = 2'd2;
  localparam logic [1:0] REG_FIRST_SERVER = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADCFG  = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_TOOLONG = 2'd3;

  typedef struct packed {
    logic [CHUNK_BITS-1:0]  chunk_bytes;
    logic [STRIPE_BITS-1:0] stripe_size;
    logic [SCNT_BITS-1:0]   server_count;
    logic [SRV_BITS-1:0]    first_server;
  } cfg_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic [END_BITS-1:0]    last_byte;
    logic                   empty;
  } req_t;

  typedef struct packed {
    logic                   go;
    logic [END_BITS-1:0]    dividend;
    logic [STRIPE_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic                   run;
    logic [END_BITS-1:0]    quot;
    logic [STRIPE_BITS-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_K,
    S_DIV_FIRST,
    S_DIV_FINAL,
    S_DIV_SQ,
    S_DIV_SRV,
    S_EMIT,
    S_ERR
  } back_state_t;

endpackage

// ===== rtl/core/scm_front.sv =====
`timescale 1ns / 1ps
module scm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [scm_pkg::OFFSET_BITS-1:0]   byte_offset,
  input  logic [scm_pkg::CNT_BITS-1:0]      byte_count,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [scm_pkg::CFG_BITS-1:0]      cfg_data,
  output scm_pkg::cfg_t                     cfg,
  input  logic                              q_full,
  output logic                              q_push,
  output scm_pkg::req_t                     q_data
);
  import scm_pkg::*;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_bytes  <= CHUNK_BITS'(16);
      cfg.stripe_size  <= STRIPE_BITS'(32);
      cfg.server_count <= SCNT_BITS'(4);
      cfg.first_server <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHUNK_BYTES:  cfg.chunk_bytes  <= cfg_data[CHUNK_BITS-1:0];
        REG_STRIPE_SIZE:  cfg.stripe_size  <= cfg_data[STRIPE_BITS-1:0];
        REG_SERVER_COUNT: cfg.server_count <= cfg_data[SCNT_BITS-1:0];
        REG_FIRST_SERVER: cfg.first_server <= cfg_data[SRV_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign busy   = q_full;
  assign q_push = start && !q_full;

  // classify and precompute the last byte touched
  always_comb begin
    q_data.offset    = byte_offset;
    q_data.last_byte = END_BITS'(byte_offset) + END_BITS'(byte_count) - END_BITS'(1);
    q_data.empty     = (byte_count == '0);
  end

endmodule

// ===== rtl/core/scm_queue.sv =====
`timescale 1ns / 1ps
module scm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scm_pkg::req_t  din,
  input  logic           pop,
  output scm_pkg::req_t  dout,
  output logic           full,
  output logic           empty
);
  import scm_pkg::*;

  req_t                 mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   fill;

  assign full  = (fill == (QPTR_BITS+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      if (push && !pop)      fill <= fill + (QPTR_BITS+1)'(1);
      else if (pop && !push) fill <= fill - (QPTR_BITS+1)'(1);
    end
  end

endmodule

// ===== rtl/core/scm_div.sv =====
`timescale 1ns / 1ps
module scm_div (
  input  logic               clk,
  input  logic               rst,
  input  scm_pkg::div_req_t  req,
  output scm_pkg::div_rsp_t  rsp
);
  import scm_pkg::*;

  logic [END_BITS-1:0]    dvd;
  logic [STRIPE_BITS-1:0] rem;
  logic [STRIPE_BITS-1:0] dsr;
  logic [DCNT_BITS-1:0]   cnt;
  logic                   run;
  logic                   done;
  logic [STRIPE_BITS:0]   trial;
  logic                   fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, dvd[END_BITS-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go && !run) begin
        run <= 1'b1;
      end else if (run && cnt == DCNT_BITS'(DIV_STEPS-1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go && !run) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      cnt <= '0;
    end else if (run) begin
      rem <= fits ? STRIPE_BITS'(trial - {1'b0, dsr}) : trial[STRIPE_BITS-1:0];
      dvd <= {dvd[END_BITS-2:0], fits};
      cnt <= cnt + DCNT_BITS'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.run  = run;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem;

endmodule

// ===== rtl/core/scm_back.sv =====
`timescale 1ns / 1ps
module scm_back (
  input  logic                             clk,
  input  logic                             rst,
  input  scm_pkg::cfg_t                    cfg,
  input  logic                             q_empty,
  input  scm_pkg::req_t                    q_data,
  output logic                             q_pop,
  output logic                             strobe,
  output logic [scm_pkg::OFFSET_BITS-1:0]  chunk_index,
  output logic [scm_pkg::SRV_BITS-1:0]     server_number,
  output logic [1:0]                       status,
  output logic                             last
);
  import scm_pkg::*;

  back_state_t state, state_next;
  div_req_t    dreq;
  div_rsp_t    drsp;

  req_t                   cur;
  logic [STRIPE_BITS-1:0] k;        // chunks per stripe unit
  logic [OFFSET_BITS-1:0] first;
  logic [END_BITS-1:0]    diff;
  logic [OFFSET_BITS-1:0] sq;
  logic [STRIPE_BITS-1:0] r;        // chunk position within its stripe unit
  logic [SRV_BITS-1:0]    srv;
  logic [OFFSET_BITS-1:0] chunk;
  logic [IDX_BITS-1:0]    idx;
  logic [1:0]             err;

  logic                   bad_cfg;
  logic                   emit_last;
  logic [SCNT_BITS-1:0]   srv_inc;

  logic                   strobe_next;
  logic [OFFSET_BITS-1:0] chunk_index_next;
  logic [SRV_BITS-1:0]    server_number_next;
  logic [1:0]             status_next;
  logic                   last_next;

  scm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign bad_cfg = (cfg.chunk_bytes == '0) || (cfg.stripe_size == '0) ||
                   (STRIPE_BITS'(cfg.chunk_bytes) > cfg.stripe_size) ||
                   (drsp.rem != '0) || (cfg.server_count == '0) ||
                   (cfg.server_count > SCNT_BITS'(MAX_SERVERS));
  assign emit_last = (idx == diff[IDX_BITS-1:0]);
  assign srv_inc   = SCNT_BITS'(srv) + SCNT_BITS'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (!q_empty) state_next = S_DIV_K;
      S_DIV_K:     if (drsp.done) begin
        if (bad_cfg || cur.empty) state_next = S_ERR;
        else                      state_next = S_DIV_FIRST;
      end
      S_DIV_FIRST: if (drsp.done) state_next = S_DIV_FINAL;
      S_DIV_FINAL: if (drsp.done) begin
        if ((drsp.quot - END_BITS'(first)) >= END_BITS'(MAX_CHUNKS)) state_next = S_ERR;
        else                                                       state_next = S_DIV_SQ;
      end
      S_DIV_SQ:    if (drsp.done) state_next = S_DIV_SRV;
      S_DIV_SRV:   if (drsp.done) state_next = S_EMIT;
      S_EMIT:      if (emit_last) state_next = S_IDLE;
      S_ERR:       state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop              = 1'b0;
    dreq.go            = 1'b0;
    dreq.dividend      = '0;
    dreq.divisor       = '0;
    strobe_next        = 1'b0;
    chunk_index_next   = '0;
    server_number_next = '0;
    status_next        = ST_OK;
    last_next          = 1'b0;
    case (state)
      S_IDLE: q_pop = !q_empty;
      S_DIV_K: begin
        dreq.go       = !drsp.run && !drsp.done;
        dreq.dividend = END_BITS'(cfg.stripe_size);
        dreq.divisor  = STRIPE_BITS'(cfg.chunk_bytes);
      end
      S_DIV_FIRST: begin
        dreq.go       = !drsp.run && !drsp.done;
        dreq.dividend = END_BITS'(cur.offset);
        dreq.divisor  = STRIPE_BITS'(cfg.chunk_bytes);
      end
      S_DIV_FINAL: begin
        dreq.go       = !drsp.run && !drsp.done;
        dreq.dividend = cur.last_byte;
        dreq.divisor  = STRIPE_BITS'(cfg.chunk_bytes);
      end
      S_DIV_SQ: begin
        dreq.go       = !drsp.run && !drsp.done;
        dreq.dividend = END_BITS'(first);
        dreq.divisor  = k;
      end
      S_DIV_SRV: begin
        dreq.go       = !drsp.run && !drsp.done;
        dreq.dividend = END_BITS'(sq) + END_BITS'(cfg.first_server);
        dreq.divisor  = STRIPE_BITS'(cfg.server_count);
      end
      S_EMIT: begin
        strobe_next        = 1'b1;
        chunk_index_next   = chunk;
        server_number_next = (cfg.server_count == SCNT_BITS'(1)) ? cfg.first_server : srv;
        last_next          = emit_last;
      end
      S_ERR: begin
        strobe_next = 1'b1;
        status_next = err;
        last_next   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    chunk_index   <= chunk_index_next;
    server_number <= server_number_next;
    status        <= status_next;
    last          <= last_next;
    case (state)
      S_IDLE: if (!q_empty) cur <= q_data;
      S_DIV_K: if (drsp.done) begin
        k   <= drsp.quot[STRIPE_BITS-1:0];
        err <= bad_cfg ? ST_BADCFG : ST_EMPTY;
      end
      S_DIV_FIRST: if (drsp.done) first <= drsp.quot[OFFSET_BITS-1:0];
      S_DIV_FINAL: if (drsp.done) begin
        diff <= drsp.quot - END_BITS'(first);
        err  <= ST_TOOLONG;
      end
      S_DIV_SQ: if (drsp.done) begin
        sq <= drsp.quot[OFFSET_BITS-1:0];
        r  <= drsp.rem;
      end
      S_DIV_SRV: if (drsp.done) begin
        srv   <= drsp.rem[SRV_BITS-1:0];
        chunk <= first;
        idx   <= '0;
      end
      S_EMIT: begin
        chunk <= chunk + OFFSET_BITS'(1);
        idx   <= idx + IDX_BITS'(1);
        // step to the next server at each stripe unit boundary
        if (r + STRIPE_BITS'(1) == k) begin
          r   <= '0;
          srv <= (srv_inc == cfg.server_count) ? '0 : srv_inc[SRV_BITS-1:0];
        end else begin
          r <= r + STRIPE_BITS'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/stripe_chunk_server_mapper_unit.sv =====
`timescale 1ns / 1ps
// Stripe chunk server mapper.
// A request (byte_offset, byte_count) is taken at a clock edge with start high
// and busy low. The block splits it into fixed-size chunks and gives one
// result per chunk, in ascending order: chunk_index and the server that holds
// it, placed round robin one stripe unit per server starting at first_server.
// Bad configuration, a zero count, or more than MAX_CHUNKS chunks give a
// single result with the matching error status instead.
// Results: strobe is high for one cycle per result; last marks the final one.
// The receiver cannot stall; results of one request come on consecutive cycles.
// Registers are written through cfg_we/cfg_index/cfg_data. The user must write
// them only while idle; the block itself does not enforce it. Each request
// takes five divisions on one shared serial divider (chunks per stripe,
// first chunk, last chunk, stripe number, server); each division loads its
// operands, makes 49 shift steps and flags done. A configuration or empty
// error is known after the first division, a too-many error after the third.
// An ok request then streams one result per cycle, and the back takes the
// next request from the queue only after the last result of the current one.
// A two-entry queue between the front and the back lets up to two requests
// wait; busy is high while it is full.
// Reset restores chunk 16, stripe 32, 4 servers, first server 0 and drops
// any queued requests.
module stripe_chunk_server_mapper_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [scm_pkg::OFFSET_BITS-1:0]   byte_offset,
  input  logic [scm_pkg::CNT_BITS-1:0]      byte_count,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [scm_pkg::CFG_BITS-1:0]      cfg_data,
  output logic                              strobe,
  output logic [scm_pkg::OFFSET_BITS-1:0]   chunk_index,
  output logic [scm_pkg::SRV_BITS-1:0]      server_number,
  output logic [1:0]                        status,
  output logic                              last
);
  import scm_pkg::*;

  cfg_t cfg;
  req_t push_data;
  req_t pop_data;
  logic push, pop, q_full, q_empty;

  // front: registers, request intake and classification
  scm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .byte_offset (byte_offset),
    .byte_count  (byte_count),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cfg         (cfg),
    .q_full      (q_full),
    .q_push      (push),
    .q_data      (push_data)
  );

  // request queue decouples intake from the mapping engine
  scm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .pop   (pop),
    .dout  (pop_data),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: divisions, then one result per cycle
  scm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .q_pop         (pop),
    .strobe        (strobe),
    .chunk_index   (chunk_index),
    .server_number (server_number),
    .status        (status),
    .last          (last)
  );

endmodule

// ===== rtl/core/scm_checker.sv =====
`timescale 1ns / 1ps
module scm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            strobe,
  input logic [scm_pkg::OFFSET_BITS-1:0] chunk_index,
  input logic [scm_pkg::SRV_BITS-1:0]    server_number,
  input logic [1:0]                      status,
  input logic                            last
);
  import scm_pkg::*;

  // error results stand alone
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_OK |-> last)
    else $error("error result without last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_OK |-> chunk_index == '0 && server_number == '0)
    else $error("error result with nonzero fields");

  // a request's results are contiguous with consecutive chunk numbers
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && status == ST_OK &&
                        chunk_index == $past(chunk_index) + OFFSET_BITS'(1))
    else $error("broken result burst");

  a_rst_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("result right after reset");

endmodule

bind stripe_chunk_server_mapper_unit scm_checker u_scm_checker (
  .clk           (clk),
  .rst           (rst),
  .strobe        (strobe),
  .chunk_index   (chunk_index),
  .server_number (server_number),
  .status        (status),
  .last          (last)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import scm_pkg::*;

  // Run limit. The slowest request takes five divisions plus up to MAX_CHUNKS
  // results. Around 500 requests and idle waits between
  // configurations fit well inside this limit.
  localparam int unsigned RUN_LIMIT = 2000000;
  // Cycles allowed after the last expected result before a register write,
  // and at the end of the run.
  localparam int DRAIN_CYCLES = 300;
  localparam int RAND_PHASES = 12;
  localparam int REQS_PER_PHASE = 38;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [CNT_BITS-1:0]    byte_count;
  logic                   cfg_we;
  logic [1:0]             cfg_index;
  logic [CFG_BITS-1:0]    cfg_data;
  logic                   strobe;
  logic [OFFSET_BITS-1:0] chunk_index;
  logic [SRV_BITS-1:0]    server_number;
  logic [1:0]             status;
  logic                   last;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] chunk;
    logic [SRV_BITS-1:0]    server;
    logic [1:0]             stat;
    logic                   fin;
  } chunk_map_t;

  // Chunk map scoreboard: holds a copy of the registers, expands each
  // accepted request into the chunk results it should produce, and matches
  // them in order against what the block sends back.
  class chunk_map_board;
    longint unsigned chunk_sz, stripe_sz, srv_cnt, base_srv;
    chunk_map_t pending[$];
    int errors;

    function new();
      chunk_sz = 16; stripe_sz = 32; srv_cnt = 4; base_srv = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
      case (idx)
        REG_CHUNK_BYTES:  chunk_sz  = 64'(val[CHUNK_BITS-1:0]);
        REG_STRIPE_SIZE:  stripe_sz = 64'(val[STRIPE_BITS-1:0]);
        REG_SERVER_COUNT: srv_cnt   = 64'(val[SCNT_BITS-1:0]);
        default:          base_srv  = 64'(val[SRV_BITS-1:0]);
      endcase
    endfunction

    function bit layout_ok();
      if (chunk_sz == 0 || stripe_sz == 0) return 0;
      if (chunk_sz > stripe_sz) return 0;
      if (stripe_sz % chunk_sz != 0) return 0;
      if (srv_cnt < 1 || srv_cnt > MAX_SERVERS) return 0;
      return 1;
    endfunction

    function void push_error(logic [1:0] st);
      chunk_map_t e;
      e = '0;
      e.stat = st;
      e.fin = 1'b1;
      pending.push_back(e);
    endfunction

    // Expand one accepted request.
    function void note_request(logic [OFFSET_BITS-1:0] off, logic [CNT_BITS-1:0] cnt);
      longint unsigned first_ck, final_ck, n, pos, srv;
      chunk_map_t e;
      if (!layout_ok()) begin
        push_error(ST_BADCFG);
        return;
      end
      if (cnt == 0) begin
        push_error(ST_EMPTY);
        return;
      end
      first_ck = longint'(off) / chunk_sz;
      final_ck = (longint'(off) + longint'(cnt) - 1) / chunk_sz;
      n = final_ck - first_ck + 1;
      if (n > MAX_CHUNKS) begin
        push_error(ST_TOOLONG);
        return;
      end
      pos = first_ck * chunk_sz;
      for (longint unsigned i = 0; i < n; i++) begin
        // one server: base is used as is, even when it is above the count
        if (srv_cnt == 1) srv = base_srv;
        else srv = (base_srv + pos / stripe_sz) % srv_cnt;
        e.chunk = OFFSET_BITS'(first_ck + i);   // wraps at the top
        e.server = srv[SRV_BITS-1:0];
        e.stat = ST_OK;
        e.fin = (i + 1 == n);
        pending.push_back(e);
        pos += chunk_sz;
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(chunk_map_t got);
      chunk_map_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result chunk=%0h srv=%0d st=%0d last=%0b",
                         got.chunk, got.server, got.stat, got.fin));
        return;
      end
      want = pending.pop_front();
      if (got.chunk !== want.chunk)
        report($sformatf("chunk_index %0h, want %0h", got.chunk, want.chunk));
      if (got.server !== want.server)
        report($sformatf("server_number %0d, want %0d", got.server, want.server));
      if (got.stat !== want.stat)
        report($sformatf("status %0d, want %0d", got.stat, want.stat));
      if (got.fin !== want.fin)
        report($sformatf("last %0b, want %0b", got.fin, want.fin));
    endtask
  endclass

  chunk_map_board board;
  int unsigned cycles;

  stripe_chunk_server_mapper_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .byte_offset(byte_offset), .byte_count(byte_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .chunk_index(chunk_index), .server_number(server_number),
    .status(status), .last(last)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Results cannot be held off; take every strobe.
  always @(posedge clk) begin
    chunk_map_t got;
    if (!rst && strobe) begin
      got.chunk = chunk_index;
      got.server = server_number;
      got.stat = status;
      got.fin = last;
      board.check_result(got);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Issue one request; start stays high so back-to-back requests in a burst
  // keep it asserted without a drop.
  task send_request(logic [OFFSET_BITS-1:0] off, logic [CNT_BITS-1:0] cnt);
    @(negedge clk);
    start = 1'b1;
    byte_offset = off;
    byte_count = cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(off, cnt);
  endtask

  task pause_sender(int n);
    @(negedge clk);
    start = 1'b0;
    byte_offset = OFFSET_BITS'({$urandom, $urandom});
    byte_count = $urandom;
    repeat (n) @(posedge clk);
  endtask

  // Let all expected results come back, then let the block settle.
  task drain();
    @(negedge clk);
    start = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_data = CFG_BITS'($urandom);
    board.set_reg(idx, val);
  endtask

  task set_layout(logic [CFG_BITS-1:0] ck, logic [CFG_BITS-1:0] st,
                  logic [CFG_BITS-1:0] sc, logic [CFG_BITS-1:0] fs);
    drain();
    write_reg(REG_CHUNK_BYTES, ck);
    write_reg(REG_STRIPE_SIZE, st);
    write_reg(REG_SERVER_COUNT, sc);
    write_reg(REG_FIRST_SERVER, fs);
  endtask

  // Random layout: mostly valid, now and then a broken one.
  task random_layout();
    logic [CFG_BITS-1:0] ck, st, sc, fs;
    ck = CFG_BITS'($urandom_range(0, 3) == 0 ? (1 << $urandom_range(0, 24))
                                             : $urandom_range(1, 5000));
    st = CFG_BITS'(ck * $urandom_range(1, 8));
    sc = CFG_BITS'($urandom_range(0, 2) == 0 ? $urandom_range(1, 8)
                                             : $urandom_range(1, MAX_SERVERS));
    fs = CFG_BITS'($urandom);
    case ($urandom_range(0, 9))
      0: st = CFG_BITS'(ck + 1 + $urandom_range(0, 3));   // mostly not a chunk multiple
      1: sc = CFG_BITS'($urandom_range(0, 1) ? 0 : $urandom_range(MAX_SERVERS + 1, 2047));
      2: ck = CFG_BITS'(ck | ($urandom << 25));           // upper data bits are dropped
      default: ;
    endcase
    if (st > CFG_BITS'(1 << 30)) st = CFG_BITS'(1 << 30);
    set_layout(ck, st, sc, fs);
  endtask

  // Mostly requests that fit in MAX_CHUNKS chunks, some too long or empty.
  task random_request();
    logic [OFFSET_BITS-1:0] off;
    logic [CNT_BITS-1:0] cnt;
    longint unsigned span;
    span = board.chunk_sz * MAX_CHUNKS;
    if (span == 0 || span > 32'hffff_ffff) span = 32'hffff_ffff;
    off = $urandom_range(0, 1) ? OFFSET_BITS'({$urandom, $urandom})
                               : OFFSET_BITS'($urandom_range(0, 4096));
    case ($urandom_range(0, 15))
      0: cnt = 0;
      1, 2: cnt = $urandom;
      3: cnt = CNT_BITS'(span - $urandom_range(0, 1));
      default: cnt = $urandom_range(1, CNT_BITS'(span));
    endcase
    send_request(off, cnt);
  endtask

  initial begin
    int burst;
    board = new();
    cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    byte_offset = '0;
    byte_count = '0;
    cfg_we = 1'b0;
    cfg_index = REG_CHUNK_BYTES;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset layout: chunk 16, stripe 32, four servers.
    send_request(0, 1);
    send_request(48'hffff_ffff_ffff, 1);
    send_request(48'hffff_ffff_ffff, 32'hffff_ffff);   // too many chunks
    send_request(48'h1234, 0);                         // empty
    send_request(0, 1024);                             // exactly 64 chunks
    send_request(0, 1025);                             // 65 chunks
    send_request(15, 2);                               // straddles two chunks
    send_request(48'h8000_0000_0000, 500);
    pause_sender(7);

    // One server, base above the count; chunk index wraps at the top.
    set_layout(1, 1, 1, 1023);
    send_request(48'hffff_ffff_fffd, 6);
    send_request(0, 64);
    send_request(0, 65);

    // Largest power-of-two sizes and the largest server count.
    set_layout(1 << 24, 1 << 30, MAX_SERVERS, 1023);
    send_request(48'hffff_ffff_ffff, 32'hffff_ffff);
    send_request(48'h0000_4000_0000, 32'h4000_0000);

    // Broken layouts: each gives a configuration error.
    set_layout(32, 16, 4, 0);                          // chunk above stripe
    send_request(0, 1);
    set_layout(32, 48, 4, 0);                          // stripe not a multiple
    send_request(0, 0);
    set_layout(16, 32, 0, 0);                          // zero servers
    send_request(0, 1);
    set_layout(16, 32, MAX_SERVERS + 1, 0);            // too many servers
    send_request(0, 1);
    set_layout(0, 32, 4, 0);                           // zero chunk
    send_request(0, 1);
    set_layout(8, 0, 4, 0);                            // zero stripe
    send_request(0, 1);

    // Random part: bursts and gaps on the sender.
    for (int p = 0; p < RAND_PHASES; p++) begin
      random_layout();
      burst = 0;
      for (int i = 0; i < REQS_PER_PHASE; i++) begin
        if (burst == 0) begin
          if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
          burst = $urandom_range(1, 6);
        end
        random_request();
        burst--;
      end
    end

    drain();
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
